// ----- rtl/mmfn_pkg.sv -----
// Package with shared types and constants for the min-max feature normalize unit.
package mmfn_pkg;

    localparam int DefaultColumns      = 256;
    localparam int DefaultFractionBits = 16;
    localparam int ColumnWidth         = 8;
    localparam int DataWidth           = 32;
    localparam int QueueDepth          = 4;

    localparam logic OP_OBSERVE   = 1'b0;
    localparam logic OP_NORMALIZE = 1'b1;

    typedef struct packed {
        logic [ColumnWidth-1:0] column;
        logic [DataWidth:0] den_mag;
        logic neg;
        logic flat;
    } div_job_t;

    function automatic logic signed [DataWidth-1:0] initial_max(input int fb);
        logic signed [63:0] m;
        begin
            m = -64'sd10000 <<< fb;
            if (m < -64'sd2147483648) begin
                m = -64'sd2147483648;
            end
            initial_max = m[DataWidth-1:0];
        end
    endfunction

endpackage

// ----- rtl/mmfn_front.sv -----
// Front part: column statistics memory with clearing pass, observe updates and job forming.
module mmfn_front
    import mmfn_pkg::*;
#(
    parameter int COLUMNS       = DefaultColumns,
    parameter int FRACTION_BITS = DefaultFractionBits
) (
    input  logic                         aclk,
    input  logic                         aresetn,
    input  logic                         in_valid,
    output logic                         in_ready,
    input  logic                         in_operation,
    input  logic [ColumnWidth-1:0]       in_column,
    input  logic signed [DataWidth-1:0]  in_sample,
    input  logic                         in_restart,
    output logic                         job_valid,
    input  logic                         job_ready,
    output div_job_t                     job,
    output logic signed [DataWidth:0]    job_num
);
    localparam int IW = (COLUMNS > 1) ? $clog2(COLUMNS) : 1;
    localparam logic signed [DataWidth-1:0] InitMax = initial_max(FRACTION_BITS);
    localparam logic signed [DataWidth-1:0] InitMin = {1'b0, {(DataWidth-1){1'b1}}};

    logic signed [DataWidth-1:0] max_mem [COLUMNS];
    logic signed [DataWidth-1:0] min_mem [COLUMNS];

    logic          clearing_reg;
    logic [IW:0]   clear_idx_reg;

    // Stage 1 registers: read issued.
    logic                        s1_valid_reg;
    logic                        s1_op_reg;
    logic                        s1_restart_reg;
    logic [ColumnWidth-1:0]      s1_column_reg;
    logic [IW-1:0]               s1_idx_reg;
    logic signed [DataWidth-1:0] s1_sample_reg;
    logic signed [DataWidth-1:0] rd_max_reg;
    logic signed [DataWidth-1:0] rd_min_reg;

    // Write-back bypass from the update in flight.
    logic                        wb_valid_reg;
    logic [IW-1:0]               wb_idx_reg;
    logic signed [DataWidth-1:0] wb_max_reg;
    logic signed [DataWidth-1:0] wb_min_reg;

    logic                        out_valid_reg;
    div_job_t                    job_reg;
    logic signed [DataWidth:0]   num_reg;

    logic [19:0]                 idx_red;
    logic [IW-1:0]               in_idx;
    logic signed [DataWidth-1:0] cur_max;
    logic signed [DataWidth-1:0] cur_min;
    logic signed [DataWidth-1:0] new_max;
    logic signed [DataWidth-1:0] new_min;
    logic signed [DataWidth:0]   num;
    logic signed [DataWidth:0]   den;
    logic                        advance;
    logic                        s1_write;

    // The column index is reduced modulo COLUMNS by shifted compare and subtract.
    always_comb begin
        idx_red = 20'(in_column);
        for (int j = 7; j >= 0; j--) begin
            if (idx_red >= (20'(COLUMNS) << j)) begin
                idx_red = idx_red - (20'(COLUMNS) << j);
            end
        end
    end

    assign in_idx   = idx_red[IW-1:0];
    assign advance  = !out_valid_reg || job_ready;
    assign in_ready = !clearing_reg && advance;

    always_comb begin
        cur_max = rd_max_reg;
        cur_min = rd_min_reg;
        if (wb_valid_reg && wb_idx_reg == s1_idx_reg) begin
            cur_max = wb_max_reg;
            cur_min = wb_min_reg;
        end
        if (s1_restart_reg) begin
            cur_max = InitMax;
            cur_min = InitMin;
        end
        new_max = (s1_sample_reg > cur_max) ? s1_sample_reg : cur_max;
        new_min = (s1_sample_reg < cur_min) ? s1_sample_reg : cur_min;
        num = {s1_sample_reg[DataWidth-1], s1_sample_reg} - {cur_min[DataWidth-1], cur_min};
        den = {cur_max[DataWidth-1], cur_max} - {cur_min[DataWidth-1], cur_min};
    end

    assign s1_write = s1_valid_reg && advance && s1_op_reg == OP_OBSERVE;

    always_ff @(posedge aclk) begin
        if (clearing_reg) begin
            max_mem[clear_idx_reg[IW-1:0]] <= InitMax;
            min_mem[clear_idx_reg[IW-1:0]] <= InitMin;
        end else if (s1_write) begin
            max_mem[s1_idx_reg] <= new_max;
            min_mem[s1_idx_reg] <= new_min;
        end
        if (in_valid && in_ready) begin
            rd_max_reg <= max_mem[in_idx];
            rd_min_reg <= min_mem[in_idx];
        end
        if (advance) begin
            s1_op_reg      <= in_operation;
            s1_restart_reg <= in_restart && in_operation == OP_OBSERVE;
            s1_column_reg  <= in_column;
            s1_idx_reg     <= in_idx;
            s1_sample_reg  <= in_sample;
            wb_idx_reg     <= s1_idx_reg;
            wb_max_reg     <= new_max;
            wb_min_reg     <= new_min;
        end
        if (advance && s1_valid_reg && s1_op_reg == OP_NORMALIZE) begin
            job_reg.column  <= s1_column_reg;
            job_reg.den_mag <= den[DataWidth] ? DataWidth'(0) - den[DataWidth:0] : den;
            job_reg.neg     <= num[DataWidth] != den[DataWidth];
            job_reg.flat    <= den == '0;
            num_reg         <= num[DataWidth] ? -num : num;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            clearing_reg  <= 1'b1;
            clear_idx_reg <= '0;
            s1_valid_reg  <= 1'b0;
            wb_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end else begin
            if (clearing_reg) begin
                clear_idx_reg <= clear_idx_reg + 1'b1;
                if (clear_idx_reg == (IW+1)'(COLUMNS - 1)) begin
                    clearing_reg <= 1'b0;
                end
            end
            if (advance) begin
                s1_valid_reg  <= in_valid && in_ready;
                wb_valid_reg  <= s1_write;
                out_valid_reg <= s1_valid_reg && s1_op_reg == OP_NORMALIZE;
            end
        end
    end

    assign job_valid = out_valid_reg;
    assign job       = job_reg;
    assign job_num   = num_reg;

    a_no_accept_clear: assert property (@(posedge aclk) disable iff (!aresetn)
        clearing_reg |-> !in_ready) else $error("item accepted during clear");
    a_stall_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        out_valid_reg && !job_ready |=> out_valid_reg) else $error("job lost");
    a_no_write_clear: assert property (@(posedge aclk) disable iff (!aresetn)
        clearing_reg |-> !s1_valid_reg) else $error("update during clear");
endmodule

// ----- rtl/mmfn_queue.sv -----
// Short FIFO that decouples the front part from the divider.
module mmfn_queue
    import mmfn_pkg::*;
(
    input  logic                       aclk,
    input  logic                       aresetn,
    input  logic                       wr_valid,
    output logic                       wr_ready,
    input  div_job_t                   wr_job,
    input  logic signed [DataWidth:0]  wr_num,
    output logic                       rd_valid,
    input  logic                       rd_ready,
    output div_job_t                   rd_job,
    output logic signed [DataWidth:0]  rd_num
);
    localparam int AW = $clog2(QueueDepth);

    div_job_t                  job_q [QueueDepth];
    logic signed [DataWidth:0] num_q [QueueDepth];
    logic [AW:0]               count_reg;
    logic [AW-1:0]             wptr_reg;
    logic [AW-1:0]             rptr_reg;
    logic                      push;
    logic                      pop;

    assign wr_ready = count_reg != (AW+1)'(QueueDepth);
    assign rd_valid = count_reg != '0;
    assign push     = wr_valid && wr_ready;
    assign pop      = rd_valid && rd_ready;
    assign rd_job   = job_q[rptr_reg];
    assign rd_num   = num_q[rptr_reg];

    always_ff @(posedge aclk) begin
        if (push) begin
            job_q[wptr_reg] <= wr_job;
            num_q[wptr_reg] <= wr_num;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            count_reg <= '0;
            wptr_reg  <= '0;
            rptr_reg  <= '0;
        end else begin
            if (push) begin
                wptr_reg <= wptr_reg + 1'b1;
            end
            if (pop) begin
                rptr_reg <= rptr_reg + 1'b1;
            end
            count_reg <= count_reg + (AW+1)'(push) - (AW+1)'(pop);
        end
    end
endmodule

// ----- rtl/mmfn_divider.sv -----
// Back part: pipelined restoring divider with saturation and output register.
module mmfn_divider
    import mmfn_pkg::*;
#(
    parameter int FRACTION_BITS = DefaultFractionBits
) (
    input  logic                         aclk,
    input  logic                         aresetn,
    input  logic                         in_valid,
    output logic                         in_ready,
    input  div_job_t                     in_job,
    input  logic signed [DataWidth:0]    in_num,
    output logic                         out_valid,
    input  logic                         out_ready,
    output logic signed [DataWidth-1:0]  out_scaled,
    output logic [ColumnWidth-1:0]       out_column,
    output logic                         out_saturated,
    output logic                         out_flat
);
    // Quotient bits: 33 integer bits plus FRACTION_BITS fraction bits, one per stage.
    localparam int QW = DataWidth + 1 + FRACTION_BITS;
    localparam int RW = DataWidth + 2;

    logic                   v_reg   [QW+1];
    logic [QW-1:0]          n_reg   [QW+1];
    logic [RW-1:0]          r_reg   [QW+1];
    logic [QW-1:0]          q_reg   [QW+1];
    logic [DataWidth:0]     d_reg   [QW+1];
    logic                   neg_reg [QW+1];
    logic                   flat_reg[QW+1];
    logic [ColumnWidth-1:0] col_reg [QW+1];

    logic                        ov_reg;
    logic signed [DataWidth-1:0] sc_reg;
    logic [ColumnWidth-1:0]      oc_reg;
    logic                        os_reg;
    logic                        of_reg;
    logic                        adv;
    logic [QW-1:0]               qf;
    logic                        sat;
    logic [DataWidth-1:0]        mag;

    assign adv      = !ov_reg || out_ready;
    assign in_ready = adv;

    always_comb begin
        qf  = q_reg[QW];
        sat = 1'b0;
        mag = qf[DataWidth-1:0];
        if (!neg_reg[QW]) begin
            if (qf > QW'(32'h7FFF_FFFF)) begin
                sat = 1'b1;
                mag = 32'h7FFF_FFFF;
            end
        end else begin
            if (qf > QW'(33'h8000_0000)) begin
                sat = 1'b1;
                mag = 32'h8000_0000;
            end
            mag = DataWidth'(0) - mag;
        end
        if (flat_reg[QW]) begin
            sat = 1'b0;
            mag = '0;
        end
    end

    always_ff @(posedge aclk) begin
        if (adv) begin
            n_reg[0]    <= {in_num[DataWidth:0], {FRACTION_BITS{1'b0}}};
            r_reg[0]    <= '0;
            q_reg[0]    <= '0;
            d_reg[0]    <= in_job.den_mag;
            neg_reg[0]  <= in_job.neg;
            flat_reg[0] <= in_job.flat;
            col_reg[0]  <= in_job.column;
            for (int i = 0; i < QW; i++) begin
                logic [RW-1:0] t;
                t = {r_reg[i][RW-2:0], n_reg[i][QW-1-i]};
                if (t >= RW'(d_reg[i])) begin
                    r_reg[i+1] <= t - RW'(d_reg[i]);
                    q_reg[i+1] <= q_reg[i] | (QW'(1) << (QW-1-i));
                end else begin
                    r_reg[i+1] <= t;
                    q_reg[i+1] <= q_reg[i];
                end
                n_reg[i+1]    <= n_reg[i];
                d_reg[i+1]    <= d_reg[i];
                neg_reg[i+1]  <= neg_reg[i];
                flat_reg[i+1] <= flat_reg[i];
                col_reg[i+1]  <= col_reg[i];
            end
            sc_reg <= mag;
            oc_reg <= col_reg[QW];
            os_reg <= sat;
            of_reg <= flat_reg[QW];
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            for (int i = 0; i <= QW; i++) begin
                v_reg[i] <= 1'b0;
            end
            ov_reg <= 1'b0;
        end else if (adv) begin
            v_reg[0] <= in_valid;
            for (int i = 0; i < QW; i++) begin
                v_reg[i+1] <= v_reg[i];
            end
            ov_reg <= v_reg[QW];
        end
    end

    assign out_valid     = ov_reg;
    assign out_scaled    = sc_reg;
    assign out_column    = oc_reg;
    assign out_saturated = os_reg;
    assign out_flat      = of_reg;

    a_flat_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        ov_reg && of_reg |-> sc_reg == '0 && !os_reg) else $error("flat result not zero");
    a_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        ov_reg && !out_ready |=> ov_reg && $stable(sc_reg)) else $error("result changed");
    a_sat_range: assert property (@(posedge aclk) disable iff (!aresetn)
        ov_reg && os_reg |-> sc_reg == 32'h7FFF_FFFF || sc_reg == 32'h8000_0000)
        else $error("bad saturation value");
endmodule

// ----- rtl/min_max_feature_normalize_unit.sv -----
// Top level of the min-max feature normalize unit.
// Throughput: one item per cycle while m_axis_tready does not stall the output; a
// normalize result passes the front registers, the job queue, the one-bit-per-stage
// divider and its output register. Observe items pass through the column memory read
// and write-back. Reset: synchronous, active low; a clearing pass over all COLUMNS
// entries follows reset, during which s_axis_tready stays low.
module min_max_feature_normalize_unit
    import mmfn_pkg::*;
#(
    parameter int COLUMNS       = DefaultColumns,
    parameter int FRACTION_BITS = DefaultFractionBits
) (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [47:0] s_axis_tdata,  // column, sample, restart, zero fill
    input  logic        s_axis_tuser,  // operation
    input  logic        m_axis_tready,
    output logic        m_axis_tvalid,
    output logic [39:0] m_axis_tdata,  // scaled, column_echo
    output logic [1:0]  m_axis_tuser   // saturated, flat_range
);
    logic                        job_valid;
    logic                        job_ready;
    div_job_t                    job;
    logic signed [DataWidth:0]   job_num;
    logic                        q_valid;
    logic                        q_ready;
    div_job_t                    q_job;
    logic signed [DataWidth:0]   q_num;
    logic signed [DataWidth-1:0] scaled;
    logic [ColumnWidth-1:0]      column_echo;
    logic                        saturated;
    logic                        flat_range;

    mmfn_front #(.COLUMNS(COLUMNS), .FRACTION_BITS(FRACTION_BITS)) u_front (
        .aclk, .aresetn,
        .in_valid(s_axis_tvalid), .in_ready(s_axis_tready),
        .in_operation(s_axis_tuser), .in_column(s_axis_tdata[7:0]),
        .in_sample(s_axis_tdata[39:8]), .in_restart(s_axis_tdata[40]),
        .job_valid, .job_ready, .job, .job_num
    );

    mmfn_queue u_queue (
        .aclk, .aresetn,
        .wr_valid(job_valid), .wr_ready(job_ready), .wr_job(job), .wr_num(job_num),
        .rd_valid(q_valid), .rd_ready(q_ready), .rd_job(q_job), .rd_num(q_num)
    );

    mmfn_divider #(.FRACTION_BITS(FRACTION_BITS)) u_div (
        .aclk, .aresetn,
        .in_valid(q_valid), .in_ready(q_ready), .in_job(q_job), .in_num(q_num),
        .out_valid(m_axis_tvalid), .out_ready(m_axis_tready),
        .out_scaled(scaled), .out_column(column_echo),
        .out_saturated(saturated), .out_flat(flat_range)
    );

    assign m_axis_tdata = {column_echo, scaled};
    assign m_axis_tuser = {flat_range, saturated};
endmodule
